FILE: rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants, codes and the controller state type of the calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ERR   = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // The divider keeps 33 quotient bits; anything larger saturates anyway.
  localparam int DIV_STEPS = 33;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MUL,
    S_DIV,
    S_DIVEND,
    S_DONE
  } state_t;

endpackage

FILE: rtl/rpn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rpn_stack_calculator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse Polish calculator over a bounded stack of signed fixed-point words.
//
//   Channel  | Direction | Signals                      | Handshake
//   ---------+-----------+------------------------------+---------------------
//   command  | in        | kind, value                  | start high, busy low
//   result   | out       | status, top_value, depth     | done, one cycle
//
// A push, an underflow or an unknown kind reports the cycle after acceptance.
// An add or subtract passes through CALC and DONE, a multiply CALC, MUL and
// DONE, a divide CALC, DIV, DIVEND and DONE, the restoring divider resolving
// one of 33 quotient bits per cycle; a divide by zero goes from CALC to DONE.
// The entry below the top is read from the stack RAM in the accept cycle.
// Reset clears the depth and the top register; the RAM is not cleared.
// Results cannot be stalled; busy holds off the next word until done.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [KIND_W-1:0]          kind,
  input  logic signed [DATA_W-1:0]   value,
  output logic                       busy,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic signed [DATA_W-1:0]   top_value,
  output logic [DEPTH_W-1:0]         depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t state, state_next;

  logic [CW-1:0]            count;
  logic signed [DATA_W-1:0] tos;
  logic [KIND_W-1:0]        op_kind;
  logic signed [DATA_W-1:0] res;
  logic                     res_sat;
  logic signed [63:0]       prod;
  logic [31:0]              div_rem;
  logic [32:0]              div_q;
  logic [31:0]              div_dvsr;
  logic                     div_neg;
  logic                     div_ovf;
  logic [DIV_CNT_W-1:0]     step_cnt;

  logic                     accept;
  logic                     is_op;
  logic                     can_pop;
  logic                     can_push;
  logic [AW-1:0]            addr_b;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;
  logic [DATA_W-1:0]        rd_data;
  logic [31:0]              count_ext;

  logic signed [DATA_W-1:0] opb;
  logic signed [32:0]       sum33;
  logic signed [32:0]       diff33;
  logic signed [63:0]       mul_sh;
  logic [31:0]              mag_a;
  logic [31:0]              mag_b;
  logic [63:0]              dvd;
  logic [31:0]              rem_init;
  logic [32:0]              trial;
  logic                     trial_ge;
  logic [32:0]              trial_sub;

  assign accept   = start && !busy;
  assign is_op    = (kind == KIND_ADD) || (kind == KIND_SUB) ||
                    (kind == KIND_MUL) || (kind == KIND_DIV);
  assign can_pop  = count >= CW'(2);
  assign can_push = count < CW'(STACK_DEPTH);
  assign addr_b   = AW'(count - CW'(2));

  assign count_ext = 32'(count);
  assign depth     = count_ext[DEPTH_W-1:0];
  assign top_value = tos;

  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_b),
    .rdata (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && is_op && can_pop) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        case (op_kind)
          KIND_MUL: state_next = S_MUL;
          KIND_DIV: state_next = (tos == '0) ? S_DONE : S_DIV;
          default:  state_next = S_DONE;
        endcase
      end
      S_MUL:    state_next = S_DONE;
      S_DIV: begin
        if (step_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_DIVEND;
        end
      end
      S_DIVEND: state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs and the RAM write port. The top of stack lives in tos,
  // so an operator only needs the entry below it, read in the accept cycle.
  always_comb begin
    busy      = (state != S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = value;
    case (state)
      S_IDLE: begin
        mem_we = accept && (kind == KIND_PUSH) && can_push;
      end
      S_DONE: begin
        mem_we    = 1'b1;
        mem_waddr = addr_b;
        mem_wdata = res;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Arithmetic; a is the top (tos), b is the entry read from the RAM.
  always_comb begin
    opb       = rd_data;
    sum33     = {opb[31], opb} + {tos[31], tos};
    diff33    = {opb[31], opb} - {tos[31], tos};
    mul_sh    = prod >>> FRAC_BITS;
    mag_a     = tos[31] ? (~tos + 32'd1) : tos;
    mag_b     = opb[31] ? (~opb + 32'd1) : opb;
    dvd       = {32'd0, mag_b} << FRAC_BITS;
    rem_init  = {1'b0, dvd[63:33]};
    trial     = {div_rem, div_q[32]};
    trial_ge  = trial >= {1'b0, div_dvsr};
    trial_sub = trial - {1'b0, div_dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      tos    <= '0;
      done   <= 1'b0;
      status <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          // Only an operator with two entries to pop goes on to compute.
          done <= accept && !(is_op && can_pop);
          if (accept) begin
            if (kind == KIND_PUSH) begin
              if (can_push) begin
                count  <= count + CW'(1);
                tos    <= value;
                status <= ST_OK;
              end else begin
                status <= ST_FULL;
              end
            end else if (is_op) begin
              if (!can_pop) begin
                status <= ST_UNDER;
              end
            end else begin
              status <= ST_OK;
            end
          end
        end
        S_DONE: begin
          count  <= count - CW'(1);
          tos    <= res;
          status <= res_sat ? ST_ERR : ST_OK;
          done   <= 1'b1;
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_kind <= kind;
      end
      S_CALC: begin
        step_cnt <= '0;
        div_neg  <= opb[31] ^ tos[31];
        div_dvsr <= mag_a;
        div_rem  <= rem_init;
        div_q    <= dvd[32:0];
        div_ovf  <= rem_init >= mag_a;
        prod     <= opb * tos;
        case (op_kind)
          KIND_ADD: begin
            res_sat <= sum33[32] != sum33[31];
            if (sum33[32] != sum33[31]) begin
              res <= sum33[32] ? Q_MIN : Q_MAX;
            end else begin
              res <= sum33[31:0];
            end
          end
          KIND_SUB: begin
            res_sat <= diff33[32] != diff33[31];
            if (diff33[32] != diff33[31]) begin
              res <= diff33[32] ? Q_MIN : Q_MAX;
            end else begin
              res <= diff33[31:0];
            end
          end
          KIND_DIV: begin
            // Division by zero keeps the sign of the dividend.
            res     <= opb[31] ? Q_MIN : Q_MAX;
            res_sat <= 1'b1;
          end
          default: begin
            res_sat <= 1'b0;
          end
        endcase
      end
      S_MUL: begin
        if (!mul_sh[63] && (mul_sh[62:31] != '0)) begin
          res     <= Q_MAX;
          res_sat <= 1'b1;
        end else if (mul_sh[63] && (mul_sh[62:31] != '1)) begin
          res     <= Q_MIN;
          res_sat <= 1'b1;
        end else begin
          res     <= mul_sh[31:0];
          res_sat <= 1'b0;
        end
      end
      S_DIV: begin
        // One restoring step: the low quotient register shifts dividend
        // bits out at the top and quotient bits in at the bottom.
        step_cnt <= step_cnt + DIV_CNT_W'(1);
        div_q    <= {div_q[31:0], trial_ge};
        div_rem  <= trial_ge ? trial_sub[31:0] : trial[31:0];
      end
      S_DIVEND: begin
        if (div_neg) begin
          if (div_ovf || (div_q > 33'h0_8000_0000)) begin
            res     <= Q_MIN;
            res_sat <= 1'b1;
          end else begin
            res     <= ~div_q[31:0] + 32'd1;
            res_sat <= 1'b0;
          end
        end else begin
          if (div_ovf || (div_q[32:31] != 2'b00)) begin
            res     <= Q_MAX;
            res_sat <= 1'b1;
          end else begin
            res     <= div_q[31:0];
            res_sat <= 1'b0;
          end
        end
      end
      default: begin
        step_cnt <= step_cnt;
      end
    endcase
  end

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while an operation is in flight");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (accept && is_op && !can_pop) |=> (done && (status == ST_UNDER) && $stable(count)))
    else $error("underflow not reported or stack changed");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_PUSH) && can_push) |=> (done && (count == $past(count) + CW'(1))))
    else $error("push did not grow the stack");

endmodule

FILE: tb/tb_rpn_stack_calculator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives push and operator words into the calculator and keeps a shadow
// stack to predict the status, top value and depth of every result.
// A directed opening covers underflow, saturation, divide by zero and
// unknown kinds. Random runs that alternate between push-heavy and
// operator-heavy stretches then fill and empty the stack. The sender idles
// at random and drains the calculator at least once.
// ----------------------------------------------------------------------------
module tb_rpn_stack_calculator_top;
  import rpn_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_WORDS  = 1000;
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int TAIL_CYCLES   = 60;
  localparam int KIND_MAX_CODE = (1 << KIND_W) - 1;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
  } calc_word_t;

  // Shadow of the calculator stack plus the queue of results still owed.
  class calc_scoreboard;
    logic signed [DATA_W-1:0] entries [DEF_STACK_DEPTH];
    int unsigned              held;
    calc_word_t               owed_q [$];
    int unsigned              mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function void note_word(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
      calc_word_t w;
      longint     a;
      longint     b;
      longint     r;
      bit         sat;
      w.status = ST_OK;
      sat      = 1'b0;
      r        = 0;
      if (k == KIND_PUSH) begin
        if (held < DEF_STACK_DEPTH) begin
          entries[held] = v;
          held++;
        end else begin
          w.status = ST_FULL;
        end
      end else if (k <= KIND_DIV) begin
        if (held < 2) begin
          w.status = ST_UNDER;
        end else begin
          a = entries[held-1];
          b = entries[held-2];
          case (k)
            KIND_ADD: r = b + a;
            KIND_SUB: r = b - a;
            KIND_MUL: r = (b * a) >>> DEF_FRAC_BITS;
            default: begin
              if (a == 0) begin
                r   = (b < 0) ? Q_MIN : Q_MAX;
                sat = 1'b1;
              end else begin
                r = (b <<< DEF_FRAC_BITS) / a;
              end
            end
          endcase
          if (r > Q_MAX) begin
            r   = Q_MAX;
            sat = 1'b1;
          end else if (r < Q_MIN) begin
            r   = Q_MIN;
            sat = 1'b1;
          end
          held--;
          entries[held-1] = r[DATA_W-1:0];
          if (sat) w.status = ST_ERR;
        end
      end
      w.top_value = (held > 0) ? entries[held-1] : '0;
      w.depth     = held[DEPTH_W-1:0];
      owed_q.push_back(w);
    endfunction

    function void check_result(input logic [STATUS_W-1:0] st,
                               input logic signed [DATA_W-1:0] tv,
                               input logic [DEPTH_W-1:0] dp);
      calc_word_t exp_w;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: status %0d top %0d depth %0d",
                   $realtime, st, tv, dp);
        return;
      end
      exp_w = owed_q.pop_front();
      if (exp_w.status !== st || exp_w.top_value !== tv || exp_w.depth !== dp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected status %0d top %0d depth %0d, got %0d %0d %0d",
                   $realtime, exp_w.status, $signed(exp_w.top_value), exp_w.depth,
                   st, tv, dp);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;
  logic                     busy;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;

  calc_scoreboard sb;
  int unsigned    cycles;
  bit             idle_on;

  rpn_stack_calculator_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .value     (value),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .top_value (top_value),
    .depth     (depth)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // A result is checked before the word accepted at the same edge is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, top_value, depth);
      if (start && !busy) sb.note_word(kind, value);
    end
  end

  task automatic send_word(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    kind  <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      kind  <= KIND_W'($urandom);
      value <= $urandom;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_q();
    case ($urandom_range(7))
      0: return '0;
      1: begin
        case ($urandom_range(5))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'sd1;
          3: return -32'sd1;
          4: return 32'sd1 <<< DEF_FRAC_BITS;
          default: return -(32'sd1 <<< DEF_FRAC_BITS);
        endcase
      end
      // Values within about eight units keep products and quotients in range.
      2, 3: return $urandom_range(0, 32'h0010_0000) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                unsigned known;
    bit                push_mode;
    logic [KIND_W-1:0] k;
    sb      = new();
    cycles  = 0;
    idle_on = 1'b1;
    rst     = 1'b1;
    start   = 1'b0;
    kind    = KIND_PUSH;
    value   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Operators on an empty stack underflow, and unknown kinds do nothing.
    send_word(KIND_ADD, $urandom);
    send_word(KIND_SUB, $urandom);
    send_word(KIND_MUL, $urandom);
    send_word(KIND_DIV, $urandom);
    for (int c = KIND_DIV + 1; c <= KIND_MAX_CODE; c++)
      send_word(c[KIND_W-1:0], $urandom);
    send_word(KIND_PUSH, Q_MAX);
    send_word(KIND_MUL, $urandom);
    send_word(KIND_PUSH, Q_MAX);
    send_word(KIND_ADD, $urandom);
    send_word(KIND_PUSH, Q_MIN);
    send_word(KIND_ADD, $urandom);
    // Negative dividend over zero, then negative overflow on subtract.
    send_word(KIND_PUSH, '0);
    send_word(KIND_DIV, $urandom);
    send_word(KIND_PUSH, 32'sd1);
    send_word(KIND_SUB, $urandom);
    send_word(KIND_PUSH, Q_MIN);
    send_word(KIND_MUL, $urandom);
    send_word(KIND_PUSH, '0);
    send_word(KIND_DIV, $urandom);
    send_word(KIND_PUSH, '0);
    send_word(KIND_PUSH, '0);
    send_word(KIND_DIV, $urandom);
    send_word(KIND_PUSH, 32'shFFFD_0000);
    send_word(KIND_DIV, $urandom);
    send_word(KIND_PUSH, -32'sd1);
    send_word(KIND_MUL, $urandom);
    wait_drained();

    known     = 0;
    push_mode = 1'b1;
    while (known < RANDOM_WORDS) begin
      idle_on = !(known >= 300 && known < 500);
      if ($urandom_range(29) == 0) push_mode = !push_mode;
      if ($urandom_range(99) < 2)
        k = KIND_W'($urandom_range(KIND_DIV + 1, KIND_MAX_CODE));
      else if ($urandom_range(99) < (push_mode ? 80 : 30))
        k = KIND_PUSH;
      else
        k = KIND_W'($urandom_range(KIND_ADD, KIND_DIV));
      if (k <= KIND_DIV) known++;
      if (idle_on && $urandom_range(99) < 8)
        idle_cycles($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4));
      if (known == 650 || $urandom_range(199) == 0) wait_drained();
      send_word(k, (k == KIND_PUSH) ? rand_q() : $urandom);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      $display("%0d results never arrived", sb.owed_q.size());
      sb.mismatches += sb.owed_q.size();
    end
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
